@@ src/ssedf_pkg.sv @@
`timescale 1ns / 1ps

package ssedf_pkg;

  localparam int LINE_BYTES  = 256;
  localparam int EVENT_BYTES = 1024;

  localparam int LINE_W    = $clog2(LINE_BYTES);
  localparam int ADDR_W    = $clog2(EVENT_BYTES);
  localparam int POS_W     = $clog2(EVENT_BYTES + LINE_BYTES);
  localparam int LEN_OUT_W = 10;
  localparam int IDX_W     = 10;
  localparam int DONE_LEN  = 6;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_EVENT = 2'd0,
    RES_DONE  = 2'd1,
    RES_READ  = 2'd2
  } res_kind_t;

  localparam logic [2:0] MS_START      = 3'd0;
  localparam logic [2:0] MS_PREFIX_END = 3'd5;
  localparam logic [2:0] MS_VALUE      = 3'd6;
  localparam logic [2:0] MS_IGNORE     = 3'd7;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic                 valid;
    res_kind_t            rkind;
    logic [LEN_OUT_W-1:0] event_length;
    logic                 is_read;
    logic                 idx_ok;
    logic [31:0]          dropped;
    logic                 done;
  } res_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] ms);
    logic [7:0] c;
    unique case (ms)
      3'd0:    c = 8'h64;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] done_char(input int i);
    logic [7:0] c;
    case (i)
      0:       c = 8'h5B;
      1:       c = 8'h44;
      2:       c = 8'h4F;
      3:       c = 8'h4E;
      4:       c = 8'h45;
      5:       c = 8'h5D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ src/ssedf_store_ram.sv @@
`timescale 1ns / 1ps

module ssedf_store_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ssedf_parser.sv @@
`timescale 1ns / 1ps

module ssedf_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      byte_value,
  input  logic [ssedf_pkg::IDX_W-1:0]     read_index,
  output logic                            we,
  output logic [ssedf_pkg::ADDR_W-1:0]    waddr,
  output logic [7:0]                      wdata,
  output logic                            re,
  output logic [ssedf_pkg::ADDR_W-1:0]    raddr,
  output ssedf_pkg::res_t                 res
);

  localparam int LW = ssedf_pkg::LINE_W;
  localparam int AW = ssedf_pkg::ADDR_W;
  localparam int PW = ssedf_pkg::POS_W;
  localparam int DL = ssedf_pkg::DONE_LEN;

  logic [LW-1:0] line_length, line_length_next;
  logic          line_overflow, line_overflow_next;
  logic [2:0]    match_state, match_state_next;
  logic [LW-1:0] value_length, value_length_next;
  logic [AW-1:0] event_len, event_len_next;
  logic          event_overflow, event_overflow_next;
  logic          event_has_data, event_has_data_next;
  logic          done_seen, done_seen_next;
  logic [31:0]   dropped_count, dropped_count_next;
  logic [DL-1:0] head_match, head_match_next;

  logic          accept;
  logic          is_byte, is_lf, is_cr, is_finish, is_read, is_clear, take;
  logic          line_empty, data_line, do_end, do_close, sep, too_long;
  logic          commit_line, lf_write, line_full, put, put_write;
  logic [PW-1:0] pos_sum;
  logic [2:0]    ms_step;
  logic          has_e, ovf_e;
  logic [AW-1:0] len_e;
  logic          is_done_evt, emit_evt, drop_evt;

  always_comb begin
    accept    = in_valid && !in_stall;
    is_byte   = kind == ssedf_pkg::KIND_BYTE;
    is_finish = kind == ssedf_pkg::KIND_FINISH;
    is_read   = kind == ssedf_pkg::KIND_READ;
    is_clear  = kind == ssedf_pkg::KIND_CLEAR;
    is_lf     = is_byte && byte_value == ssedf_pkg::CH_LF;
    is_cr     = is_byte && byte_value == ssedf_pkg::CH_CR;
    take      = is_byte && !is_lf && !is_cr;

    line_empty = line_length == '0 && !line_overflow;
    data_line  = match_state == ssedf_pkg::MS_PREFIX_END || match_state == ssedf_pkg::MS_VALUE;
    do_end     = (is_lf || is_finish) && !line_empty;
    do_close   = (is_lf && line_empty) || is_finish;
    sep        = event_len != '0;
    pos_sum    = PW'(event_len) + PW'(sep) + PW'(value_length);
    too_long   = pos_sum >= PW'(ssedf_pkg::EVENT_BYTES);

    commit_line = do_end && data_line && !line_overflow && !too_long;
    lf_write    = commit_line && sep;
    has_e       = event_has_data || (do_end && data_line);
    ovf_e       = event_overflow || (do_end && data_line && (line_overflow || too_long));
    len_e       = commit_line ? AW'(pos_sum) : event_len;

    line_full = line_length == LW'(ssedf_pkg::LINE_BYTES - 1);
    put       = take && !line_full &&
                (match_state == ssedf_pkg::MS_VALUE ||
                 (match_state == ssedf_pkg::MS_PREFIX_END && byte_value != ssedf_pkg::CH_SPACE));
    put_write = put && !too_long;

    if (match_state < ssedf_pkg::MS_PREFIX_END) begin
      if (match_state == ssedf_pkg::MS_START && byte_value == ssedf_pkg::CH_COLON) begin
        ms_step = ssedf_pkg::MS_IGNORE;
      end else if (byte_value == ssedf_pkg::prefix_char(match_state)) begin
        ms_step = match_state + 3'd1;
      end else begin
        ms_step = ssedf_pkg::MS_IGNORE;
      end
    end else if (match_state == ssedf_pkg::MS_PREFIX_END) begin
      ms_step = ssedf_pkg::MS_VALUE;
    end else begin
      ms_step = match_state;
    end

    we    = accept && (put_write || lf_write);
    waddr = lf_write ? event_len : AW'(pos_sum);
    wdata = lf_write ? ssedf_pkg::CH_LF : byte_value;
    re    = accept && is_read;
    raddr = AW'(read_index);

    head_match_next = head_match;
    for (int i = 0; i < DL; i++) begin
      if (we && waddr == AW'(i)) begin
        head_match_next[i] = wdata == ssedf_pkg::done_char(i);
      end
    end

    is_done_evt = len_e == AW'(DL) && &head_match_next;
    emit_evt    = do_close && has_e && !ovf_e;
    drop_evt    = do_close && has_e && ovf_e;

    done_seen_next     = done_seen || (emit_evt && is_done_evt);
    dropped_count_next = dropped_count + 32'(drop_evt);

    line_length_next   = line_length;
    line_overflow_next = line_overflow;
    match_state_next   = match_state;
    value_length_next  = value_length;
    if (is_lf || is_finish) begin
      line_length_next   = '0;
      line_overflow_next = 1'b0;
      match_state_next   = ssedf_pkg::MS_START;
      value_length_next  = '0;
    end else if (take) begin
      if (line_full) begin
        line_overflow_next = 1'b1;
      end else begin
        line_length_next  = line_length + LW'(1);
        match_state_next  = ms_step;
        value_length_next = value_length + LW'(put);
      end
    end

    event_len_next      = do_close ? '0 : len_e;
    event_overflow_next = do_close ? 1'b0 : ovf_e;
    event_has_data_next = do_close ? 1'b0 : has_e;

    res.valid        = accept && (emit_evt || is_read);
    res.is_read      = is_read;
    res.idx_ok       = 32'(read_index) < 32'(ssedf_pkg::EVENT_BYTES);
    res.dropped      = dropped_count_next;
    res.done         = done_seen_next;
    if (is_read) begin
      res.rkind        = ssedf_pkg::RES_READ;
      res.event_length = '0;
    end else if (is_done_evt) begin
      res.rkind        = ssedf_pkg::RES_DONE;
      res.event_length = '0;
    end else begin
      res.rkind        = ssedf_pkg::RES_EVENT;
      res.event_length = ssedf_pkg::LEN_OUT_W'(len_e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      line_overflow  <= 1'b0;
      match_state    <= ssedf_pkg::MS_START;
      value_length   <= '0;
      event_len      <= '0;
      event_overflow <= 1'b0;
      event_has_data <= 1'b0;
      done_seen      <= 1'b0;
      dropped_count  <= '0;
    end else if (accept) begin
      if (is_clear) begin
        line_length    <= '0;
        line_overflow  <= 1'b0;
        match_state    <= ssedf_pkg::MS_START;
        value_length   <= '0;
        event_len      <= '0;
        event_overflow <= 1'b0;
        event_has_data <= 1'b0;
        done_seen      <= 1'b0;
        dropped_count  <= '0;
      end else begin
        line_length    <= line_length_next;
        line_overflow  <= line_overflow_next;
        match_state    <= match_state_next;
        value_length   <= value_length_next;
        event_len      <= event_len_next;
        event_overflow <= event_overflow_next;
        event_has_data <= event_has_data_next;
        done_seen      <= done_seen_next;
        dropped_count  <= dropped_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_match <= head_match_next;
    end
  end

  a_event_len_bound: assert property (@(posedge clk) disable iff (rst)
    !event_has_data |-> event_len == '0)
    else $error("event length without data");

  a_value_in_line: assert property (@(posedge clk) disable iff (rst)
    value_length <= line_length)
    else $error("value longer than line");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    accept && is_clear |=> event_len == '0 && dropped_count == '0 && !done_seen &&
                           !event_has_data && line_length == '0)
    else $error("clear left state behind");

endmodule

@@ src/ssedf_out_stage.sv @@
`timescale 1ns / 1ps

module ssedf_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  ssedf_pkg::res_t                   res,
  input  logic [7:0]                        ram_q,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        result_kind,
  output logic [ssedf_pkg::LEN_OUT_W-1:0]   event_length,
  output logic [7:0]                        read_byte,
  output logic [31:0]                       dropped_events,
  output logic                              done_flag
);

  ssedf_pkg::res_t s1;
  logic            s1_valid;
  logic            out_take;

  always_comb begin
    out_take = !out_valid || !out_stall;
    in_stall = s1_valid && !out_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= res.valid || (s1_valid && !out_take);
      if (out_take) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      s1 <= res;
    end
    if (out_take && s1_valid) begin
      result_kind    <= s1.rkind;
      event_length   <= s1.event_length;
      read_byte      <= (s1.is_read && s1.idx_ok) ? ram_q : 8'h00;
      dropped_events <= s1.dropped;
      done_flag      <= s1.done;
    end
  end

  a_held_read_data: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.is_read && !out_take |=> $stable(ram_q))
    else $error("store read data lost while held");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_take |=> out_valid)
    else $error("held item did not reach output");

endmodule

@@ src/sse_data_event_deframer_core.sv @@
`timescale 1ns / 1ps

// Server-Sent Events data deframer. Takes one stream byte, finish, store read or clear
// per item and accepts an item every cycle while the output moves; a result is held in
// a registered stage, beside the registered read of the event store RAM (one write
// and one read port), and then in the output register. The store needs no clearing pass
// after reset. The "[DONE]" check runs on flags that mirror the first six store entries,
// so closing an event takes no extra store reads.
module sse_data_event_deframer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        byte_value,
  input  logic [ssedf_pkg::IDX_W-1:0]       read_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        result_kind,
  output logic [ssedf_pkg::LEN_OUT_W-1:0]   event_length,
  output logic [7:0]                        read_byte,
  output logic [31:0]                       dropped_events,
  output logic                              done_flag
);

  logic                         we;
  logic [ssedf_pkg::ADDR_W-1:0] waddr;
  logic [7:0]                   wdata;
  logic                         re;
  logic [ssedf_pkg::ADDR_W-1:0] raddr;
  logic [7:0]                   ram_q;
  ssedf_pkg::res_t              res;

  ssedf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .byte_value (byte_value),
    .read_index (read_index),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .res        (res)
  );

  ssedf_store_ram #(
    .DATA_W (8),
    .DEPTH  (ssedf_pkg::EVENT_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  ssedf_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .res            (res),
    .ram_q          (ram_q),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .event_length   (event_length),
    .read_byte      (read_byte),
    .dropped_events (dropped_events),
    .done_flag      (done_flag)
  );

endmodule
